// ----- sv/acr_pkg.sv -----
// shared constants, codes and helper functions for the access counter
`default_nettype none

package acr_pkg;

    // default sizes
    localparam int RECENT_DEPTH_DEF   = 10;
    localparam int MAP_INDEX_BITS_DEF = 10;

    // field widths
    localparam int KIND_W     = 7;
    localparam int SERIAL_W   = 32;
    localparam int ADDR_W     = 64;
    localparam int KEY_W      = 32;
    localparam int TIME_W     = 31;
    localparam int COUNT_W    = 31;
    localparam int POP_W      = 11;
    localparam int HIT_W      = 8;
    localparam int CMP_W      = 64;

    // stream word widths, padded to whole bytes
    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 240;
    localparam int IN_PAD_W   = IN_DATA_W - (SERIAL_W + 2 * ADDR_W + KEY_W + TIME_W);
    localparam int OUT_PAD_W  = OUT_DATA_W - (3 * COUNT_W + POP_W + HIT_W + 4 * TIME_W);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED_KINDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_ONLY     = 1'b1;

    // kind bits that matter for duplicate suppression
    localparam logic [KIND_W-1:0] KIND_TOTAL   = 7'h01;
    localparam logic [KIND_W-1:0] KIND_REFERER = 7'h10;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 7'h20;
    localparam logic [KIND_W-1:0] KIND_DEST    = 7'h40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // saturating increment of a 31-bit total
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // kinds that are suppressed when the request serial repeats
    function automatic logic is_dedup(input logic [KIND_W-1:0] k);
        return !(k == KIND_REFERER || k == KIND_ERROR || k == KIND_TOTAL ||
                 k == (KIND_TOTAL | KIND_REFERER) || k == KIND_DEST);
    endfunction

endpackage

`default_nettype wire

// ----- sv/acr_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module acr_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/access_counter_recent_clients.sv -----
// page access counter with recent client key list and network map
//
//  channel  signals                             direction  contents
//  cfg      cfg_valid/ready, cfg_index, data    in         register writes
//  s        s_tvalid/tready, s_tdata, s_tuser   in         one access per word
//  m        m_tvalid/tready, m_tdata, m_tuser   out        counts after the access
//
// an item is checked for enable, read-only and a repeated serial; a skipped item goes
// straight to the finish step. a counted item compares the two client address halves,
// then searches the key list one compare per cycle on the shared comparator, stopping
// on a hit, an empty slot or the last entry; a miss adds one map read-modify-write.
// after reset the network map, 2^(MAP_INDEX_BITS-3) rows, is cleared one byte row
// per cycle, during which s_tready stays low.
// a new word is taken while a finished result waits on the m side; the block
// holds in its finish step only if that result is still not taken.
`default_nettype none

module access_counter_recent_clients
    import acr_pkg::*;
#(
    parameter int RECENT_DEPTH   = RECENT_DEPTH_DEF,
    parameter int MAP_INDEX_BITS = MAP_INDEX_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // request_serial, client_addr_high, client_addr_low, client_key, time_now
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  wire logic [KIND_W-1:0]     s_tuser,
    // output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // total_accesses, client_changes, new_keys, networks_seen, key_hit_count,
    // created_time, last_update_time, last_change_time, last_new_key_time
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // counted
    output logic                       m_tuser
);

    localparam int PTR_W    = $clog2(RECENT_DEPTH);
    localparam int ROW_W    = MAP_INDEX_BITS - 3;
    localparam int MAP_ROWS = 1 << ROW_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RECENT_DEPTH - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAP_ROWS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ADDR_HI,
        ST_ADDR_LO,
        ST_SEARCH,
        ST_MAP,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [KIND_W-1:0] enabled_kinds_reg;
    logic              read_only_reg;

    // latched input word
    logic [KIND_W-1:0]   kind_reg;
    logic [SERIAL_W-1:0] serial_reg;
    logic [ADDR_W-1:0]   addr_hi_reg;
    logic [ADDR_W-1:0]   addr_lo_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [TIME_W-1:0]   now_reg;

    // counter state
    logic [COUNT_W-1:0]  access_total_reg;
    logic [COUNT_W-1:0]  change_total_reg;
    logic [COUNT_W-1:0]  new_key_total_reg;
    logic [POP_W-1:0]    pop_reg;
    logic [ADDR_W-1:0]   prev_hi_reg;
    logic [ADDR_W-1:0]   prev_lo_reg;
    logic [SERIAL_W-1:0] prev_serial_reg;
    logic [TIME_W-1:0]   ts_created_reg;
    logic [TIME_W-1:0]   ts_update_reg;
    logic [TIME_W-1:0]   ts_change_reg;
    logic [TIME_W-1:0]   ts_newkey_reg;
    logic [KEY_W-1:0]    key_list_reg [RECENT_DEPTH];
    logic [HIT_W-1:0]    hit_list_reg [RECENT_DEPTH];

    // sequencer working registers
    logic [PTR_W-1:0]    ptr_reg;
    logic [ROW_W-1:0]    clr_ptr_reg;
    logic                diff_reg;
    logic                counted_reg;

    // output register
    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                m_user_reg;

    // combinational helpers
    logic [KEY_W-1:0]    entry_key;
    logic [HIT_W-1:0]    entry_hit;
    logic [CMP_W-1:0]    cmp_a;
    logic [CMP_W-1:0]    cmp_b;
    logic                cmp_eq;
    logic                allowed;
    logic                dedup;
    logic                entry_empty;
    logic                search_hit;
    logic                search_miss;
    logic [MAP_INDEX_BITS-1:0] map_idx;
    logic [ROW_W-1:0]    map_row;
    logic [HIT_W-1:0]    bit_mask;
    logic                bit_set;
    logic                ram_we;
    logic [ROW_W-1:0]    ram_waddr;
    logic [HIT_W-1:0]    ram_wdata;
    logic [HIT_W-1:0]    ram_rdata;
    logic [COUNT_W-1:0]  access_total_next;
    logic [COUNT_W-1:0]  change_total_next;
    logic [COUNT_W-1:0]  new_key_total_next;
    logic [OUT_DATA_W-1:0] m_data_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_kinds_reg <= '0;
            read_only_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLED_KINDS: enabled_kinds_reg <= cfg_data;
                REG_READ_ONLY:     read_only_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // list entry under the search pointer
    assign entry_key = key_list_reg[ptr_reg];
    assign entry_hit = hit_list_reg[ptr_reg];

    // shared equality comparator, operands picked by the sequencer step
    always_comb
    begin
        case (state_reg)
            ST_CHECK:
            begin
                cmp_a = CMP_W'(serial_reg);
                cmp_b = CMP_W'(prev_serial_reg);
            end
            ST_ADDR_HI:
            begin
                cmp_a = addr_hi_reg;
                cmp_b = prev_hi_reg;
            end
            ST_ADDR_LO:
            begin
                cmp_a = addr_lo_reg;
                cmp_b = prev_lo_reg;
            end
            ST_SEARCH:
            begin
                cmp_a = CMP_W'(key_reg);
                cmp_b = CMP_W'(entry_key);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_eq = (cmp_a == cmp_b);

    // skip decision
    assign allowed = !read_only_reg && ((kind_reg & enabled_kinds_reg) != '0);
    assign dedup   = is_dedup(kind_reg);

    // search outcome; an empty slot ends the search as a miss
    assign entry_empty = (entry_key == '0);
    assign search_hit  = !entry_empty && cmp_eq;
    assign search_miss = entry_empty || (!cmp_eq && ptr_reg == LAST_PTR);

    // network map addressing from the top key bits
    assign map_idx  = key_reg[KEY_W-1 -: MAP_INDEX_BITS];
    assign map_row  = map_idx[MAP_INDEX_BITS-1:3];
    assign bit_mask = HIT_W'(1) << map_idx[2:0];
    assign bit_set  = (ram_rdata & bit_mask) != '0;

    // map ram: clearing pass after reset, then set-bit writes
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_MAP && !bit_set);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_ptr_reg : map_row;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : (ram_rdata | bit_mask);

    acr_ram #(
        .WIDTH (HIT_W),
        .DEPTH (MAP_ROWS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (map_row),
        .rdata (ram_rdata)
    );

    // saturating totals
    assign access_total_next  = sat_inc(access_total_reg);
    assign change_total_next  = sat_inc(change_total_reg);
    assign new_key_total_next = sat_inc(new_key_total_reg);

    // result word
    assign m_data_next = {OUT_PAD_W'(0), ts_newkey_reg, ts_change_reg, ts_update_reg,
                          ts_created_reg, hit_list_reg[0], pop_reg, new_key_total_reg,
                          change_total_reg, access_total_reg};

    // sequencer with counter state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            access_total_reg  <= '0;
            change_total_reg  <= '0;
            new_key_total_reg <= '0;
            pop_reg           <= '0;
            prev_hi_reg       <= '0;
            prev_lo_reg       <= '0;
            prev_serial_reg   <= '1;
            ts_created_reg    <= '0;
            ts_update_reg     <= '0;
            ts_change_reg     <= '0;
            ts_newkey_reg     <= '0;
            for (int j = 0; j < RECENT_DEPTH; j++)
            begin
                key_list_reg[j] <= '0;
                hit_list_reg[j] <= '0;
            end
            ptr_reg           <= '0;
            clr_ptr_reg       <= '0;
            diff_reg          <= 1'b0;
            counted_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
            m_user_reg        <= 1'b0;
        end
        else
        begin
            // output handshake; the finish step reloads the register itself
            if (m_valid_reg && m_tready && state_reg != ST_FINISH)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                // clear the network map one row per cycle
                ST_CLEAR:
                begin
                    clr_ptr_reg <= clr_ptr_reg + 1'b1;
                    if (clr_ptr_reg == LAST_ROW)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                // take one input word
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg    <= s_tuser;
                        serial_reg  <= s_tdata[SERIAL_W-1:0];
                        addr_hi_reg <= s_tdata[SERIAL_W +: ADDR_W];
                        addr_lo_reg <= s_tdata[SERIAL_W + ADDR_W +: ADDR_W];
                        key_reg     <= s_tdata[SERIAL_W + 2 * ADDR_W +: KEY_W];
                        now_reg     <= s_tdata[SERIAL_W + 2 * ADDR_W + KEY_W +: TIME_W];
                        state_reg   <= ST_CHECK;
                    end
                end

                // enable, read-only and duplicate serial checks
                ST_CHECK:
                begin
                    if (!allowed || (dedup && cmp_eq))
                    begin
                        counted_reg <= 1'b0;
                        state_reg   <= ST_FINISH;
                    end
                    else
                    begin
                        if (dedup)
                        begin
                            prev_serial_reg <= serial_reg;
                        end
                        counted_reg      <= 1'b1;
                        access_total_reg <= access_total_next;
                        if (ts_created_reg == '0)
                        begin
                            ts_created_reg <= now_reg;
                        end
                        ts_update_reg <= now_reg;
                        state_reg     <= ST_ADDR_HI;
                    end
                end

                // upper half of the client address
                ST_ADDR_HI:
                begin
                    diff_reg  <= !cmp_eq;
                    state_reg <= ST_ADDR_LO;
                end

                // lower half; record a change of client
                ST_ADDR_LO:
                begin
                    if (diff_reg || !cmp_eq)
                    begin
                        change_total_reg <= change_total_next;
                        ts_change_reg    <= now_reg;
                        prev_hi_reg      <= addr_hi_reg;
                        prev_lo_reg      <= addr_lo_reg;
                    end
                    ptr_reg   <= '0;
                    state_reg <= ST_SEARCH;
                end

                // one list entry per cycle
                ST_SEARCH:
                begin
                    if (search_hit)
                    begin
                        // move the hit entry to the front
                        for (int j = 0; j < RECENT_DEPTH; j++)
                        begin
                            if (j == 0)
                            begin
                                key_list_reg[0] <= entry_key;
                                hit_list_reg[0] <= entry_hit + 1'b1;
                            end
                            else if (PTR_W'(j) <= ptr_reg)
                            begin
                                key_list_reg[j] <= key_list_reg[j-1];
                                hit_list_reg[j] <= hit_list_reg[j-1];
                            end
                        end
                        state_reg <= ST_FINISH;
                    end
                    else if (search_miss)
                    begin
                        // shift in the new key at the front
                        for (int j = 0; j < RECENT_DEPTH; j++)
                        begin
                            if (j == 0)
                            begin
                                key_list_reg[0] <= key_reg;
                                hit_list_reg[0] <= '0;
                            end
                            else
                            begin
                                key_list_reg[j] <= key_list_reg[j-1];
                                hit_list_reg[j] <= hit_list_reg[j-1];
                            end
                        end
                        new_key_total_reg <= new_key_total_next;
                        ts_newkey_reg     <= now_reg;
                        state_reg         <= ST_MAP;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end

                // map row read back; set the bit if new
                ST_MAP:
                begin
                    if (!bit_set)
                    begin
                        pop_reg <= pop_reg + 1'b1;
                    end
                    state_reg <= ST_FINISH;
                end

                // load the output register once it is free
                ST_FINISH:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= m_data_next;
                        m_user_reg  <= counted_reg;
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an accepted word makes the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while busy");

    // a new result word appears only from the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
    else $error("result word loaded outside finish step");

    // the map population moves only after a map read-back
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_reg != $past(pop_reg)) |-> $past(state_reg == ST_MAP))
    else $error("population changed outside map step");

    // the new-key total moves only on a counted access
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(new_key_total_reg) |-> counted_reg)
    else $error("new key counted on a skipped access");

endmodule

`default_nettype wire
